// ===== sv/arr_pkg.sv =====
// Shared types and constants for the apparent resistivity reciprocity unit.
// Holds the request and response word layouts and the fixed-point widths.
// No dependencies; used by arr_ptable and apparent_resistivity_reciprocity_unit.
package arr_pkg;

   localparam int ELECTRODES_DEF = 64;

   // Opcodes of a request word.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DATUM = 1'b1;

   localparam int POT_W = 32;   // Q8.24 potential
   localparam int VOLT_W = 35;  // sum of four potentials
   localparam int MAG_W = 41;   // resistivity magnitude, Q.16
   localparam int PROD_W = 82;  // product of two magnitudes
   localparam int ROOT_STEPS = PROD_W / 2;
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic              opcode;
      logic [5:0]        load_source;
      logic [5:0]        load_point;
      logic signed [31:0] load_value;
      logic [6:0]        current_a;
      logic [6:0]        current_b;
      logic [6:0]        meas_a;
      logic [6:0]        meas_b;
      logic signed [31:0] geometric_factor;
      logic              clear_max;
   } req_type;

   typedef struct packed {
      logic signed [31:0] apparent_resistivity;
      logic [31:0]        reciprocity_error;
      logic [31:0]        max_reciprocity_error;
   } rsp_type;

endpackage

// ===== sv/arr_ptable.sv =====
// Potential table: one synchronous memory, one write and one read port.
// Read data is registered, so it appears the cycle after the read request.
// Depends on arr_pkg for the word width.
module arr_ptable #(
   parameter int DEPTH = arr_pkg::ELECTRODES_DEF * arr_pkg::ELECTRODES_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [AW-1:0]                wr_addr,
   input  logic [arr_pkg::POT_W-1:0]    wr_data,
   input  logic                         rd_en,
   input  logic [AW-1:0]                rd_addr,
   output logic [arr_pkg::POT_W-1:0]    rd_data
);

   logic [arr_pkg::POT_W-1:0] mem_ff [DEPTH];
   logic [arr_pkg::POT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/apparent_resistivity_reciprocity_unit.sv =====
// Top level of the apparent resistivity reciprocity unit.
// Depends on arr_pkg and arr_ptable (the potential table memory).
//
//   channel   direction  handshake          word
//   req_      in         req_valid/stall    arr_pkg::req_type (load or datum)
//   rsp_      out        rsp_valid/stall    arr_pkg::rsp_type (one per datum)
//
// A load word is taken while the unit is idle and writes the table directly.
// A datum runs its steps in order: the eight table reads through the single
// memory read port, the two resistivity products, the magnitude product,
// the bit-serial square root (the division runs alongside), and the finish.
// Reset clears the running maximum and control state; the table is undefined until written.
// A stalled response holds its word; a new datum may be accepted while it waits.
module apparent_resistivity_reciprocity_unit #(
   parameter int ELECTRODES = arr_pkg::ELECTRODES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  arr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output arr_pkg::rsp_type rsp_data
);

   localparam int TABLE_DEPTH = ELECTRODES * ELECTRODES;
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int VW = arr_pkg::VOLT_W;
   localparam int MW = arr_pkg::MAG_W;
   localparam int PW = arr_pkg::PROD_W;
   localparam logic signed [MW+1:0] RHO_MAX = (MW+2)'(64'sd2147483647);
   localparam logic signed [MW+1:0] RHO_MIN = (MW+2)'(-64'sd2147483648);

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SCALE, ST_PROD, ST_ROOT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic use_entry;
      logic neg;
      logic recip;
   } rd_tag_type;

   function automatic logic electrode_ok(input logic [6:0] e);
      return (e != 7'd0) && (int'(e) <= ELECTRODES);
   endfunction

   state_type          state_ff;
   logic [5:0]         cnt_ff;
   arr_pkg::req_type   datum_ff;
   rd_tag_type         pend_ff;
   rd_tag_type         pend_in;
   logic signed [VW-1:0] vg_ff, vr_ff;
   logic [63:0]        plo_ff;
   logic signed [MW:0] rg_ff, rr_ff;
   logic [PW-1:0]      prod_ff;
   logic [MW-1:0]      root_ff;
   logic [MW:0]        rem_ff;
   logic [VW-1:0]      div_rem_ff;
   logic [31:0]        div_q_ff;
   logic [VW-2:0]      mg_ff;
   logic               err_force_ff;
   logic [31:0]        max_ff;
   logic               rsp_valid_ff;
   arr_pkg::rsp_type   rsp_ff;

   // Request side.
   logic accept, accept_load, accept_datum, load_ok;
   logic [AW-1:0] wr_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign accept_load = accept && (req_data.opcode == arr_pkg::OP_LOAD);
   assign accept_datum = accept && (req_data.opcode == arr_pkg::OP_DATUM);
   assign load_ok = (int'(req_data.load_source) < ELECTRODES)
                 && (int'(req_data.load_point) < ELECTRODES);
   assign wr_addr = AW'(int'(req_data.load_source) * ELECTRODES
                      + int'(req_data.load_point));

   // Table read sequence: forward terms first, then reciprocal terms.
   logic [2:0] rd_k;
   logic [6:0] rd_src, rd_pt;
   logic       rd_en;
   logic [AW-1:0] rd_addr;
   logic [arr_pkg::POT_W-1:0] rd_data;
   logic signed [VW-1:0] rd_term;

   always_comb begin
      rd_k = cnt_ff[2:0];
      rd_src = rd_k[2] ? (rd_k[1] ? datum_ff.meas_b : datum_ff.meas_a)
                       : (rd_k[1] ? datum_ff.current_b : datum_ff.current_a);
      rd_pt = rd_k[2] ? (rd_k[0] ? datum_ff.current_b : datum_ff.current_a)
                      : (rd_k[0] ? datum_ff.meas_b : datum_ff.meas_a);
      rd_en = (state_ff == ST_READ) && !cnt_ff[3];
      rd_addr = AW'((int'(rd_src) - 1) * ELECTRODES + (int'(rd_pt) - 1));
      pend_in.valid = rd_en;
      pend_in.use_entry = electrode_ok(rd_src) && electrode_ok(rd_pt);
      pend_in.neg = rd_k[1] ^ rd_k[0];
      pend_in.recip = rd_k[2];
      rd_term = pend_ff.use_entry ? {{(VW-32){rd_data[31]}}, rd_data} : '0;
   end

   arr_ptable #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ptable (
      .clock   (clock),
      .wr_en   (accept_load && load_ok),
      .wr_addr (wr_addr),
      .wr_data (req_data.load_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Resistivity scaling: factor times voltage in two partial products.
   logic signed [VW-1:0] sc_v;
   logic [VW-1:0]  sc_v_neg;
   logic [VW-2:0]  sc_mv;
   logic [31:0]    fac_neg, sc_mf;
   logic [63:0]    mul_lo;
   logic [33:0]    mul_hi;
   logic [65:0]    sc_full;
   logic [MW-1:0]  sc_mag;
   logic signed [MW:0] sc_res;

   always_comb begin
      sc_v = cnt_ff[1] ? vr_ff : vg_ff;
      sc_v_neg = -sc_v;
      sc_mv = sc_v[VW-1] ? sc_v_neg[VW-2:0] : sc_v[VW-2:0];
      fac_neg = -datum_ff.geometric_factor;
      sc_mf = datum_ff.geometric_factor[31] ? fac_neg : datum_ff.geometric_factor;
      mul_lo = sc_mf * sc_mv[31:0];
      mul_hi = sc_mf * sc_mv[33:32];
      sc_full = {2'b00, plo_ff} + {mul_hi, 32'd0};
      sc_mag = sc_full[64:24];
      sc_res = (datum_ff.geometric_factor[31] ^ sc_v[VW-1])
             ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
   end

   // Division operands for the reciprocity error.
   logic signed [VW:0] dv_diff;
   logic [VW:0]    dv_diff_neg;
   logic [VW-1:0]  dv_md, vg_neg;
   logic [VW-2:0]  dv_mg;
   logic           dv_force, dv_sat;

   always_comb begin
      dv_diff = {vr_ff[VW-1], vr_ff} - {vg_ff[VW-1], vg_ff};
      dv_diff_neg = -dv_diff;
      dv_md = dv_diff[VW] ? dv_diff_neg[VW-1:0] : dv_diff[VW-1:0];
      vg_neg = -vg_ff;
      dv_mg = vg_ff[VW-1] ? vg_neg[VW-2:0] : vg_ff[VW-2:0];
      dv_force = (datum_ff.geometric_factor == 32'sd0) || (vg_ff == '0);
      // The quotient overflows 32 bits when md >= mg * 2^8.
      dv_sat = {7'd0, dv_md} >= {dv_mg, 8'd0};
   end

   // Magnitude product from 21-bit pieces, one partial product a cycle.
   logic [MW:0]   rg_neg, rr_neg;
   logic [MW-1:0] pm_a, pm_b;
   logic [20:0]   pm_x, pm_y;
   logic [41:0]   pm_pp;
   logic [PW-1:0] pm_sh;

   always_comb begin
      rg_neg = -rg_ff;
      rr_neg = -rr_ff;
      pm_a = rg_ff[MW] ? rg_neg[MW-1:0] : rg_ff[MW-1:0];
      pm_b = rr_ff[MW] ? rr_neg[MW-1:0] : rr_ff[MW-1:0];
      pm_x = cnt_ff[1] ? {1'b0, pm_a[40:21]} : pm_a[20:0];
      pm_y = cnt_ff[0] ? {1'b0, pm_b[40:21]} : pm_b[20:0];
      pm_pp = pm_x * pm_y;
      case (cnt_ff[1:0])
         2'd0:    pm_sh = PW'(pm_pp);
         2'd1:    pm_sh = PW'(pm_pp) << 21;
         2'd2:    pm_sh = PW'(pm_pp) << 21;
         default: pm_sh = PW'(pm_pp) << 42;
      endcase
   end

   // One digit of the restoring square root and one quotient bit a cycle.
   logic [MW+1:0] rt_rem, rt_trial, rt_diff;
   logic          rt_ge;
   logic [VW-1:0] dq_t, dq_diff;
   logic          dq_ge;

   always_comb begin
      rt_rem = {rem_ff[MW-1:0], prod_ff[PW-1:PW-2]};
      rt_trial = {root_ff, 2'b01};
      rt_ge = rt_rem >= rt_trial;
      rt_diff = rt_rem - rt_trial;
      dq_t = {div_rem_ff[VW-2:0], div_q_ff[31]};
      dq_ge = dq_t >= {1'b0, mg_ff};
      dq_diff = dq_t - {1'b0, mg_ff};
   end

   // Sign-aware geometric mean and result word.
   logic signed [MW+1:0] fn_s, fn_rg, fn_rr, fn_rho;
   logic signed [31:0]   fn_rho32;
   logic [31:0]          fn_err, fn_max;
   logic                 rsp_fire;

   always_comb begin
      fn_s = $signed({1'b0, 1'b0, root_ff});
      fn_rg = {rg_ff[MW], rg_ff};
      fn_rr = {rr_ff[MW], rr_ff};
      if (!fn_rr[MW+1]) begin
         if (!fn_rg[MW+1]) fn_rho = fn_s;
         else if (fn_rg >= -fn_rr) fn_rho = fn_rg + fn_s;
         else fn_rho = fn_rr - fn_s;
      end else begin
         if (fn_rg <= 0) fn_rho = -fn_s;
         else if (fn_rg <= -fn_rr) fn_rho = fn_rg - fn_s;
         else fn_rho = fn_rr + fn_s;
      end
      if (fn_rho > RHO_MAX) fn_rho32 = 32'sh7FFFFFFF;
      else if (fn_rho < RHO_MIN) fn_rho32 = 32'sh80000000;
      else fn_rho32 = fn_rho[31:0];
      fn_err = err_force_ff ? '1 : div_q_ff;
      fn_max = (fn_err > max_ff) ? fn_err : max_ff;
      rsp_fire = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         pend_ff <= '0;
         max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (pend_ff.valid) begin
            if (pend_ff.recip) begin
               vr_ff <= pend_ff.neg ? vr_ff - rd_term : vr_ff + rd_term;
            end else begin
               vg_ff <= pend_ff.neg ? vg_ff - rd_term : vg_ff + rd_term;
            end
         end

         if (rsp_fire) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff.apparent_resistivity <= fn_rho32;
            rsp_ff.reciprocity_error <= fn_err;
            rsp_ff.max_reciprocity_error <= fn_max;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept_datum) begin
                  datum_ff <= req_data;
                  vg_ff <= '0;
                  vr_ff <= '0;
                  cnt_ff <= '0;
                  if (req_data.clear_max) begin
                     max_ff <= '0;
                  end
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               if (cnt_ff == 6'd8) begin
                  cnt_ff <= '0;
                  state_ff <= ST_SCALE;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_SCALE: begin
               if (!cnt_ff[0]) begin
                  plo_ff <= mul_lo;
               end else if (cnt_ff[1]) begin
                  rr_ff <= sc_res;
               end else begin
                  rg_ff <= sc_res;
               end
               if (cnt_ff == 6'd3) begin
                  mg_ff <= dv_mg;
                  div_rem_ff <= {8'd0, dv_md[VW-1:8]};
                  div_q_ff <= {dv_md[7:0], 24'd0};
                  err_force_ff <= dv_force || dv_sat;
                  cnt_ff <= '0;
                  state_ff <= ST_PROD;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_PROD: begin
               prod_ff <= ((cnt_ff == 6'd0) ? '0 : prod_ff) + pm_sh;
               if (cnt_ff == 6'd3) begin
                  root_ff <= '0;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= ST_ROOT;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_ROOT: begin
               prod_ff <= prod_ff << 2;
               root_ff <= {root_ff[MW-2:0], rt_ge};
               rem_ff <= rt_ge ? rt_diff[MW:0] : rt_rem[MW:0];
               if (int'(cnt_ff) < arr_pkg::DIV_STEPS) begin
                  div_rem_ff <= dq_ge ? dq_diff : dq_t;
                  div_q_ff <= {div_q_ff[30:0], dq_ge};
               end
               if (int'(cnt_ff) == arr_pkg::ROOT_STEPS - 1) begin
                  cnt_ff <= '0;
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            ST_FINISH: begin
               if (rsp_fire) begin
                  max_ff <= fn_max;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_datum_starts_read: assert property (@(posedge clock) disable iff (reset)
      accept_datum |=> (state_ff == ST_READ))
      else $error("accepted datum did not start the table reads");

   a_read_only_in_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff.valid |-> (state_ff == ST_READ))
      else $error("table read returned outside the read phase");

   a_max_covers_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.max_reciprocity_error >= rsp_ff.reciprocity_error))
      else $error("running maximum below the error of the same word");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROOT) && !err_force_ff) |-> ({1'b0, mg_ff} > div_rem_ff))
      else $error("division remainder not below the divisor");

   a_fire_only_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised without a finished datum");

endmodule
